@@ hdl/bjet_pkg.sv @@
// Package for the Blaschke Julia escape-time core: constants, types, state codes.
// No dependencies.
`timescale 1ns / 1ps
package bjet_pkg;
   localparam int DataWidthDef = 32;
   localparam int FracBitsDef  = 24;
   localparam int IterBitsDef  = 10;
   localparam int ColorWidth   = 14;
   localparam int CsrIdxWidth  = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_EXPONENTS = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_POLE_R    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_B2_RE     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_B2_IM     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_B3_RE     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_B3_IM     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_ITER  = 3'd6;

   localparam logic [1:0] OUTCOME_LIMIT  = 2'd0;
   localparam logic [1:0] OUTCOME_ZERO   = 2'd1;
   localparam logic [1:0] OUTCOME_ESCAPE = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_NORM, OP_POW_INIT, OP_MUL_W, OP_MOB_PREP,
      OP_DIV_PREP, OP_DIV_STEP, OP_DIV_DONE, OP_RECIP, OP_ACC_INIT, OP_ACC_MUL,
      OP_Z_UPDATE, OP_CMUL_A, OP_CMUL_B
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NORM0, ST_NORM1, ST_CHECK, ST_FACTOR, ST_MOB_A, ST_MOB_B, ST_MOB_C,
      ST_DIV_A, ST_DIV_B, ST_DIV_C, ST_DIV_D, ST_DIV_RUN, ST_DIV_END,
      ST_POW_CHK, ST_POW_MUL_A, ST_POW_MUL_B, ST_ACC_A, ST_ACC_B, ST_NEXT,
      ST_RESULT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] sub;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_zero;
   } dp_status_type;
endpackage

@@ hdl/bjet_if.sv @@
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload width set by parameter.
`timescale 1ns / 1ps
interface bjet_if #(parameter int PayloadWidth = 64);
   logic                    valid;
   logic                    ready;
   logic [PayloadWidth-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/bjet_alu.sv @@
// Shared fixed-point arithmetic unit: one saturating multiply a cycle,
// and a restoring divider retiring one quotient bit a cycle. Uses bjet_pkg.
`timescale 1ns / 1ps
module bjet_alu
   import bjet_pkg::*;
#(
   parameter int DataWidth = DataWidthDef,
   parameter int FracBits  = FracBitsDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [DataWidth-1:0] mul_a,
   input  logic signed [DataWidth-1:0] mul_b,
   output logic signed [DataWidth-1:0] mul_y,
   input  logic                        div_start,
   input  logic signed [DataWidth-1:0] div_num,
   input  logic signed [DataWidth-1:0] div_den,
   output logic                        div_busy,
   output logic signed [DataWidth-1:0] div_q
);
   localparam int PW = 2 * DataWidth;
   localparam int NW = DataWidth + FracBits;
   localparam int CW = $clog2(NW + 1);
   localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};

   logic [DataWidth-1:0] ma, mb;
   logic [PW-1:0]        prod, sh;
   logic                 mneg;

   // magnitude product, truncate, saturate
   always_comb begin
      ma    = mul_a[DataWidth-1] ? DataWidth'(-mul_a) : mul_a;
      mb    = mul_b[DataWidth-1] ? DataWidth'(-mul_b) : mul_b;
      mneg  = mul_a[DataWidth-1] ^ mul_b[DataWidth-1];
      prod  = PW'(ma) * PW'(mb);
      sh    = prod >> FracBits;
      if (!mneg) begin
         mul_y = (sh > PW'(VMax)) ? VMax : DataWidth'(sh);
      end else begin
         mul_y = (sh > PW'(VMax) + PW'(1)) ? VMin : DataWidth'(-sh);
      end
   end

   logic [NW-1:0]        num_ff, num_in, quo_ff, quo_in;
   logic [DataWidth:0]   rem_ff, rem_in, trial;
   logic [DataWidth-1:0] den_ff, den_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 neg_ff, neg_in, busy_ff, busy_in;
   logic [DataWidth-1:0] nmag;
   logic signed [DataWidth-1:0] q_ff, q_in;

   // one quotient bit per cycle
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      nmag    = div_num[DataWidth-1] ? DataWidth'(-div_num) : div_num;
      trial   = {rem_ff[DataWidth-1:0], num_ff[NW-1]};
      if (div_start) begin
         if (div_den == '0) begin
            q_in = div_num[DataWidth-1] ? VMin : VMax;
         end else begin
            num_in  = {nmag, {FracBits{1'b0}}};
            den_in  = div_den[DataWidth-1] ? DataWidth'(-div_den) : div_den;
            neg_in  = div_num[DataWidth-1] ^ div_den[DataWidth-1];
            rem_in  = '0;
            quo_in  = '0;
            cnt_in  = CW'(NW);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            if (!neg_ff) begin
               q_in = (quo_in > NW'(VMax)) ? VMax : DataWidth'(quo_in);
            end else begin
               q_in = (quo_in > NW'(VMax) + NW'(1)) ? VMin : DataWidth'(-quo_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign div_busy = busy_ff;
   assign div_q    = q_ff;
endmodule

@@ hdl/bjet_datapath.sv @@
// Datapath: register file for z, accumulator, Moebius terms and powers,
// sequenced by micro-commands. Uses bjet_pkg and bjet_alu.
`timescale 1ns / 1ps
module bjet_datapath
   import bjet_pkg::*;
#(
   parameter int DataWidth = DataWidthDef,
   parameter int FracBits  = FracBitsDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   input  logic signed [DataWidth-1:0] start_re,
   input  logic signed [DataWidth-1:0] start_im,
   input  logic signed [DataWidth-1:0] pole_re,
   input  logic signed [DataWidth-1:0] pole_im,
   output dp_status_type               status,
   output logic signed [DataWidth-1:0] norm
);
   localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic signed [DataWidth-1:0] One =
      (FracBits >= DataWidth - 1) ? VMax : DataWidth'(64'd1 << FracBits);

   function automatic logic signed [DataWidth-1:0] sadd(
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b);
      logic signed [DataWidth:0] s;
      s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      if (s[DataWidth] != s[DataWidth-1]) return s[DataWidth] ? VMin : VMax;
      return s[DataWidth-1:0];
   endfunction

   function automatic logic signed [DataWidth-1:0] ssub(
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b);
      logic signed [DataWidth:0] s;
      s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
      if (s[DataWidth] != s[DataWidth-1]) return s[DataWidth] ? VMin : VMax;
      return s[DataWidth-1:0];
   endfunction

   // working registers
   logic signed [DataWidth-1:0] zr_ff, zi_ff, ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [DataWidth-1:0] wr_ff, wi_ff, nr_ff, ni_ff, dr_ff, di_ff;
   logic signed [DataWidth-1:0] t0_ff, t1_ff, t2_ff, t3_ff, den_ff, qr_ff, nm_ff;
   logic signed [DataWidth-1:0] zr_in, zi_in, ar_in, ai_in, br_in, bi_in;
   logic signed [DataWidth-1:0] wr_in, wi_in, nr_in, ni_in, dr_in, di_in;
   logic signed [DataWidth-1:0] t0_in, t1_in, t2_in, t3_in, den_in, qr_in, nm_in;

   logic signed [DataWidth-1:0] ma, mb, my, dn, dd, dq;
   logic                        dstart, dbusy;

   bjet_alu #(.DataWidth(DataWidth), .FracBits(FracBits)) u_alu (
      .clock(clock), .reset(reset), .mul_a(ma), .mul_b(mb), .mul_y(my),
      .div_start(dstart), .div_num(dn), .div_den(dd), .div_busy(dbusy), .div_q(dq));

   // one multiply per cycle, result lands in t0..t3, den or the norm register by sub slot
   always_comb begin
      {zr_in, zi_in, ar_in, ai_in, br_in, bi_in} = {zr_ff, zi_ff, ar_ff, ai_ff, br_ff, bi_ff};
      {wr_in, wi_in, nr_in, ni_in, dr_in, di_in} = {wr_ff, wi_ff, nr_ff, ni_ff, dr_ff, di_ff};
      {t0_in, t1_in, t2_in, t3_in, den_in, qr_in, nm_in} =
         {t0_ff, t1_ff, t2_ff, t3_ff, den_ff, qr_ff, nm_ff};
      ma = '0; mb = '0; dstart = 1'b0; dn = '0; dd = '0;
      case (cmd.op)
         OP_LOAD: begin
            zr_in = start_re; zi_in = start_im;
         end
         OP_NORM: begin
            // sub0: zr^2, sub1: zi^2 and sum
            ma = cmd.sub[0] ? zi_ff : zr_ff;
            mb = ma;
            if (cmd.sub[0]) nm_in = sadd(t0_ff, my);
            else t0_in = my;
         end
         OP_MOB_PREP: begin
            // sub0..3: pole_re*zr, pole_im*zi, pole_re*zi, pole_im*zr; sub4: form num and den
            case (cmd.sub)
               3'd0: begin ma = pole_re; mb = zr_ff; t0_in = my; end
               3'd1: begin ma = pole_im; mb = zi_ff; t1_in = my; end
               3'd2: begin ma = pole_re; mb = zi_ff; t2_in = my; end
               3'd3: begin ma = pole_im; mb = zr_ff; t3_in = my; end
               default: begin
                  nr_in = ssub(zr_ff, pole_re);
                  ni_in = ssub(zi_ff, pole_im);
                  dr_in = ssub(One, sadd(t0_ff, t1_ff));
                  di_in = ssub('0, ssub(t2_ff, t3_ff));
               end
            endcase
         end
         OP_RECIP: begin
            nr_in = One; ni_in = '0; dr_in = br_ff; di_in = bi_ff;
         end
         OP_DIV_PREP: begin
            // sub0: c^2 sub1: d^2 -> den; sub2: ac sub3: bd sub4: bc sub5: ad
            case (cmd.sub)
               3'd0: begin ma = dr_ff; mb = dr_ff; t0_in = my; end
               3'd1: begin ma = di_ff; mb = di_ff; den_in = sadd(t0_ff, my); end
               3'd2: begin ma = nr_ff; mb = dr_ff; t0_in = my; end
               3'd3: begin ma = ni_ff; mb = di_ff; t1_in = my; end
               3'd4: begin ma = ni_ff; mb = dr_ff; t2_in = my; end
               default: begin ma = nr_ff; mb = di_ff; t3_in = my; end
            endcase
         end
         OP_DIV_STEP: begin
            // sub0 start real part, sub1 start imaginary part
            dstart = 1'b1;
            dd = den_ff;
            dn = cmd.sub[0] ? ssub(t2_ff, t3_ff) : sadd(t0_ff, t1_ff);
         end
         OP_DIV_DONE: begin
            if (cmd.sub[0]) begin
               br_in = qr_ff; bi_in = dq;
            end else begin
               qr_in = dq;
            end
         end
         OP_POW_INIT: begin
            // sub0: base from z; sub1: w = base; sub2: w = 1
            if (cmd.sub == 3'd0) begin
               br_in = zr_ff; bi_in = zi_ff;
            end else if (cmd.sub == 3'd1) begin
               wr_in = br_ff; wi_in = bi_ff;
            end else begin
               wr_in = One; wi_in = '0;
            end
         end
         OP_MUL_W: begin
            // w = w * base; sub0..3 products, sub4 combine
            case (cmd.sub)
               3'd0: begin ma = wr_ff; mb = br_ff; t0_in = my; end
               3'd1: begin ma = wi_ff; mb = bi_ff; t1_in = my; end
               3'd2: begin ma = wr_ff; mb = bi_ff; t2_in = my; end
               3'd3: begin ma = wi_ff; mb = br_ff; t3_in = my; end
               default: begin
                  wr_in = ssub(t0_ff, t1_ff); wi_in = sadd(t2_ff, t3_ff);
               end
            endcase
         end
         OP_ACC_INIT: begin
            ar_in = wr_ff; ai_in = wi_ff;
         end
         OP_ACC_MUL: begin
            case (cmd.sub)
               3'd0: begin ma = ar_ff; mb = wr_ff; t0_in = my; end
               3'd1: begin ma = ai_ff; mb = wi_ff; t1_in = my; end
               3'd2: begin ma = ar_ff; mb = wi_ff; t2_in = my; end
               3'd3: begin ma = ai_ff; mb = wr_ff; t3_in = my; end
               default: begin
                  ar_in = ssub(t0_ff, t1_ff); ai_in = sadd(t2_ff, t3_ff);
               end
            endcase
         end
         OP_Z_UPDATE: begin
            zr_in = ar_ff; zi_in = ai_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      {zr_ff, zi_ff, ar_ff, ai_ff, br_ff, bi_ff} <= {zr_in, zi_in, ar_in, ai_in, br_in, bi_in};
      {wr_ff, wi_ff, nr_ff, ni_ff, dr_ff, di_ff} <= {wr_in, wi_in, nr_in, ni_in, dr_in, di_in};
      {t0_ff, t1_ff, t2_ff, t3_ff, den_ff, qr_ff, nm_ff} <=
         {t0_in, t1_in, t2_in, t3_in, den_in, qr_in, nm_in};
   end

   assign status.div_busy = dbusy;
   assign status.div_zero = (den_ff == '0);
   assign norm = nm_ff;
endmodule

@@ hdl/bjet_ctrl.sv @@
// Controller: sequences the map over the four factors and decides the outcome.
// Uses bjet_pkg; drives bjet_datapath through dp_cmd_type.
`timescale 1ns / 1ps
module bjet_ctrl
   import bjet_pkg::*;
#(
   parameter int DataWidth = DataWidthDef,
   parameter int FracBits  = FracBitsDef,
   parameter int IterBits  = IterBitsDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   output logic                        load,
   output logic                        out_valid,
   input  logic                        out_ready,
   input  logic [19:0]                 exponents,
   input  logic [IterBits-1:0]         max_iter,
   input  logic signed [DataWidth-1:0] norm,
   input  dp_status_type               status,
   output dp_cmd_type                  cmd,
   output logic [1:0]                  factor,
   output logic [ColorWidth-1:0]       color_index,
   output logic [1:0]                  outcome,
   output logic [IterBits-1:0]         iterations,
   output logic                        started_inside
);
   localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] One =
      (FracBits >= DataWidth - 1) ? VMax : DataWidth'(64'd1 << FracBits);
   localparam logic [DataWidth+6:0] LoRaw = ((DataWidth+7)'(1) << FracBits) + 50;
   localparam logic signed [DataWidth-1:0] Lo =
      (LoRaw / 100 > (DataWidth+7)'(VMax)) ? VMax : DataWidth'(LoRaw / 100);
   localparam logic signed [DataWidth-1:0] Hi =
      (((DataWidth+7)'(100) << FracBits) > (DataWidth+7)'(VMax)) ? VMax :
      DataWidth'(64'd100 << FracBits);

   ctl_state_type state_ff, state_in;
   logic [2:0]    sub_ff, sub_in;
   logic [1:0]    fac_ff, fac_in;
   logic [4:0]    pc_ff, pc_in;
   logic          rcp_ff, rcp_in, first_ff, first_in, ins_ff, ins_in;
   logic [IterBits-1:0] it_ff, it_in;
   logic [1:0]    oc_ff, oc_in;
   logic signed [4:0] ex;
   logic [4:0]    exmag;

   always_comb begin
      case (fac_ff)
         2'd0:    ex = exponents[4:0];
         2'd1:    ex = exponents[9:5];
         2'd2:    ex = exponents[14:10];
         default: ex = exponents[19:15];
      endcase
      exmag = ex[4] ? 5'(-ex) : ex;
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff; sub_in = sub_ff; fac_in = fac_ff; pc_in = pc_ff;
      rcp_in = rcp_ff; first_in = first_ff; ins_in = ins_ff; it_in = it_ff; oc_in = oc_ff;
      cmd.op = OP_NONE; cmd.sub = sub_ff;
      in_ready = 1'b0; load = 1'b0; out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               load = 1'b1; cmd.op = OP_LOAD; it_in = '0; state_in = ST_NORM0;
            end
         end
         ST_NORM0: begin
            cmd.op = OP_NORM; cmd.sub = 3'd0; state_in = ST_NORM1;
         end
         ST_NORM1: begin
            cmd.op = OP_NORM; cmd.sub = 3'd1; state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (it_ff == '0) ins_in = (norm < One);
            if (it_ff >= max_iter) begin
               oc_in = OUTCOME_LIMIT; state_in = ST_RESULT;
            end else if (norm <= Lo || norm >= Hi) begin
               oc_in = (norm < Lo) ? OUTCOME_ZERO : OUTCOME_ESCAPE; state_in = ST_RESULT;
            end else begin
               fac_in = '0; first_in = 1'b1; state_in = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            if (fac_ff == 2'd0) begin
               cmd.op = OP_POW_INIT; cmd.sub = 3'd0; state_in = ST_POW_CHK;
               rcp_in = ex[4];
               if (ex[4]) state_in = ST_MOB_C;
            end else begin
               sub_in = '0; state_in = ST_MOB_A;
            end
         end
         ST_MOB_A: begin
            cmd.op = OP_MOB_PREP;
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               sub_in = '0; state_in = ST_DIV_A;
            end
         end
         ST_MOB_C: begin
            cmd.op = OP_RECIP; sub_in = '0; state_in = ST_DIV_A;
         end
         ST_DIV_A: begin
            cmd.op = OP_DIV_PREP;
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd5) state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            cmd.op = OP_DIV_STEP; cmd.sub = 3'd0;
            state_in = status.div_zero ? ST_DIV_C : ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) state_in = ST_DIV_C;
         end
         ST_DIV_C: begin
            cmd.op = OP_DIV_DONE; cmd.sub = 3'd0;
            cmd.op = OP_DIV_DONE;
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.op = OP_DIV_STEP; cmd.sub = 3'd1;
            state_in = status.div_zero ? ST_DIV_END : ST_MOB_B;
         end
         ST_MOB_B: begin
            if (!status.div_busy) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.op = OP_DIV_DONE; cmd.sub = 3'd1;
            // base now holds quotient; invert again if exponent negative
            if (fac_ff != 2'd0 && ex[4] && !rcp_ff) begin
               rcp_in = 1'b1; state_in = ST_MOB_C;
            end else begin
               state_in = ST_POW_CHK;
            end
         end
         ST_POW_CHK: begin
            pc_in = 5'd1;
            if (exmag == '0) begin
               cmd.op = OP_POW_INIT; cmd.sub = 3'd2; state_in = ST_ACC_A;
            end else begin
               cmd.op = OP_POW_INIT; cmd.sub = 3'd1;
               state_in = (exmag == 5'd1) ? ST_ACC_A : ST_POW_MUL_A;
            end
            sub_in = '0;
         end
         ST_POW_MUL_A: begin
            cmd.op = OP_MUL_W;
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               sub_in = '0; pc_in = pc_ff + 5'd1;
               if (pc_ff + 5'd1 >= exmag) state_in = ST_ACC_A;
            end
         end
         ST_ACC_A: begin
            sub_in = '0;
            if (first_ff) begin
               cmd.op = OP_ACC_INIT; first_in = 1'b0; state_in = ST_NEXT;
            end else begin
               state_in = ST_ACC_B;
            end
         end
         ST_ACC_B: begin
            cmd.op = OP_ACC_MUL;
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               sub_in = '0; state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            rcp_in = 1'b0;
            if (fac_ff == 2'd3) begin
               cmd.op = OP_Z_UPDATE; it_in = it_ff + IterBits'(1); state_in = ST_NORM0;
            end else begin
               fac_in = fac_ff + 2'd1; state_in = ST_FACTOR;
            end
         end
         ST_RESULT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sub_ff <= sub_in; fac_ff <= fac_in; pc_ff <= pc_in; rcp_ff <= rcp_in;
      first_ff <= first_in; ins_ff <= ins_in; it_ff <= it_in; oc_ff <= oc_in;
   end

   // result fields
   always_comb begin
      if (oc_ff == OUTCOME_LIMIT) color_index = '1;
      else color_index = ColorWidth'(it_ff) * ColorWidth'(6) + (ins_ff ? ColorWidth'(32) : '0)
                         + ((oc_ff == OUTCOME_ESCAPE) ? ColorWidth'(8) : '0);
   end
   assign outcome        = oc_ff;
   assign iterations     = it_ff;
   assign started_inside = ins_ff;
   assign factor         = fac_ff;

   a_result_state: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> state_ff == ST_RESULT) else $error("result outside result state");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && oc_ff != OUTCOME_LIMIT) |-> it_ff < max_iter)
      else $error("iteration count over limit");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(it_ff))
      else $error("result dropped");
endmodule

@@ hdl/blaschke_julia_escape_time_core.sv @@
// Top level of the Blaschke Julia escape-time core: configuration registers,
// controller and datapath. Uses bjet_pkg, bjet_if, bjet_ctrl, bjet_datapath.
//  channel | dir | payload
//  req     | in  | start_re, start_im
//  rsp     | out | color_index, outcome, iterations, started_inside
//  csr     | in  | csr_we, csr_index, csr_wdata
// Each map application runs on the single shared multiplier and the bit-serial
// divider: one complex multiply per extra power of each factor, and one complex
// division per Moebius factor, one more per negative exponent. Items run one at a
// time, with the handshakes and the final band check between them.
// Reset is synchronous; it clears control state and sets configuration registers to defaults.
// The result is held until taken; a new request is taken after that.
`timescale 1ns / 1ps
module blaschke_julia_escape_time_core
   import bjet_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef,
   parameter int ITER_BITS  = IterBitsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   bjet_if.sink                  req,
   bjet_if.source                rsp,
   input  logic                  csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0] csr_wdata
);
   logic [19:0]                  exp_ff;
   logic signed [DATA_WIDTH-1:0] pr_ff, b2r_ff, b2i_ff, b3r_ff, b3i_ff;
   logic [ITER_BITS-1:0]         mi_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= 20'd67686;
         pr_ff  <= DATA_WIDTH'(32'sd20132659);
         b2r_ff <= DATA_WIDTH'(32'sd10066330);
         b2i_ff <= DATA_WIDTH'(32'sd17435395);
         b3r_ff <= DATA_WIDTH'(-32'sd10066330);
         b3i_ff <= DATA_WIDTH'(32'sd17435395);
         mi_ff  <= ITER_BITS'(50);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPONENTS: exp_ff <= 20'(csr_wdata);
            CSR_POLE_R:    pr_ff  <= csr_wdata;
            CSR_B2_RE:     b2r_ff <= csr_wdata;
            CSR_B2_IM:     b2i_ff <= csr_wdata;
            CSR_B3_RE:     b3r_ff <= csr_wdata;
            CSR_B3_IM:     b3i_ff <= csr_wdata;
            CSR_MAX_ITER:  mi_ff  <= ITER_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [1:0]    factor;
   logic          load;
   logic signed [DATA_WIDTH-1:0] norm, pre, pim;
   logic [ColorWidth-1:0] color;
   logic [1:0]            oc;
   logic [ITER_BITS-1:0]  its;
   logic                  ins;

   // pole for current factor
   always_comb begin
      case (factor)
         2'd1:    begin pre = pr_ff;  pim = '0;     end
         2'd2:    begin pre = b2r_ff; pim = b2i_ff; end
         2'd3:    begin pre = b3r_ff; pim = b3i_ff; end
         default: begin pre = '0;     pim = '0;     end
      endcase
   end

   bjet_ctrl #(.DataWidth(DATA_WIDTH), .FracBits(FRAC_BITS), .IterBits(ITER_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready), .load(load),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .exponents(exp_ff), .max_iter(mi_ff),
      .norm(norm), .status(status), .cmd(cmd), .factor(factor), .color_index(color),
      .outcome(oc), .iterations(its), .started_inside(ins));

   bjet_datapath #(.DataWidth(DATA_WIDTH), .FracBits(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .start_re(req.payload[DATA_WIDTH-1:0]), .start_im(req.payload[2*DATA_WIDTH-1:DATA_WIDTH]),
      .pole_re(pre), .pole_im(pim), .status(status), .norm(norm));

   assign rsp.payload = {ins, its, oc, color};
endmodule
